@@ hdl/bole_pkg.sv @@
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned IN_VALUE_W      = 32;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned POS_W           = 4;
  localparam int unsigned COUNT_W         = 5;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_BACK  = 3'd0,
    K_PUSH_FRONT = 3'd1,
    K_FIND       = 3'd2,
    K_DELETE     = 3'd3,
    K_POP_FRONT  = 3'd4,
    K_POP_BACK   = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    S_OK        = 2'd0,
    S_EMPTY     = 2'd1,
    S_NOT_FOUND = 2'd2,
    S_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    C_HOLD,
    C_APPEND,
    C_PUSH_FRONT,
    C_REMOVE,
    C_COMPARE,
    C_SCAN
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN
  } state_e;

endpackage

@@ hdl/bounded_ordered_list_engine_unit.sv @@
// Top level of the bounded ordered list engine: request control, cell chain and result register.
//
// Requests enter on the input channel (kind_i, value_i) and are accepted when in_valid_i
// is high and in_stall_o is low. Each request yields exactly one word on the output channel
// (status_o, position_o, entry_count_o), taken when out_valid_o is high and out_stall_i low.
// The list lives in a chain of CAPACITY cells; push-front and pop-front move every cell at once,
// push-back writes only the tail cell and pop-back only lowers the count. Push, pop and
// unused-code requests pass from idle to the dispatch state, which registers the result word.
// Find and delete first compare every cell in parallel, then shift the match flags toward
// the front one cell per cycle. A hit is reported when its flag reaches the front cell; a
// miss once the scan reaches the last occupied entry. Find and delete on an empty list are
// answered from the dispatch state. The input stall drops as the result word is registered.
// The result register decouples the two channels: a new request is taken while a word waits.
// When the receiver stalls and the register is still full, the request in progress
// holds until the word is taken.
// Reset empties the list and drops any pending word; no clearing pass is needed.
module bounded_ordered_list_engine_unit import bole_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [KIND_W-1:0]            kind_i,
  input  logic signed [IN_VALUE_W-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic [POS_W-1:0]             position_o,
  output logic [COUNT_W-1:0]           entry_count_o
);

  localparam int unsigned OW = $clog2(CAPACITY+1);
  localparam int unsigned IW = $clog2(CAPACITY);

  state_e                  state_q, state_d;
  logic [KIND_W-1:0]       kind_q;
  logic [VALUE_WIDTH-1:0]  val_q;
  logic [OW-1:0]           occ_q, occ_d;
  logic [IW-1:0]           idx_q, idx_d;
  cell_op_e                cell_op;
  logic [VALUE_WIDTH-1:0]  entry_w [CAPACITY];
  logic                    match_w [CAPACITY];
  logic signed [63:0]      value_ext;
  logic                    accept;
  logic                    out_free;
  logic                    res_valid;
  status_e                 res_status;
  logic [POS_W-1:0]        res_pos;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     status_q;
  logic [POS_W-1:0]        pos_q;
  logic [COUNT_W-1:0]      count_q;
  logic                    full;
  logic                    empty;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign value_ext  = 64'(value_i);
  assign full       = (occ_q == OW'(CAPACITY));
  assign empty      = (occ_q == '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_entry;
    logic [VALUE_WIDTH-1:0] next_entry;
    logic                   next_match;
    if (i == 0) begin : g_head
      assign prev_entry = val_q;
    end else begin : g_body
      assign prev_entry = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entry_w[i];
      assign next_match = 1'b0;
    end else begin : g_inner
      assign next_entry = entry_w[i+1];
      assign next_match = match_w[i+1];
    end
    bole_cell #(
      .CAPACITY   (CAPACITY),
      .VALUE_WIDTH(VALUE_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .occ_i       (occ_q),
      .idx_i       (idx_q),
      .value_i     (val_q),
      .prev_entry_i(prev_entry),
      .next_entry_i(next_entry),
      .next_match_i(next_match),
      .entry_o     (entry_w[i]),
      .match_o     (match_w[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    idx_d      = idx_q;
    cell_op    = C_HOLD;
    res_valid  = 1'b0;
    res_status = S_OK;
    res_pos    = '0;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (kind_q == K_FIND || kind_q == K_DELETE) begin
          if (!empty) begin
            cell_op = C_COMPARE;
            idx_d   = '0;
            state_d = ST_SCAN;
          end else if (out_free) begin
            res_valid  = 1'b1;
            res_status = S_EMPTY;
            state_d    = ST_IDLE;
          end
        end else if (out_free) begin
          res_valid = 1'b1;
          state_d   = ST_IDLE;
          case (kind_q)
            K_PUSH_BACK: begin
              if (full) begin
                res_status = S_FULL;
              end else begin
                cell_op = C_APPEND;
                res_pos = POS_W'(occ_q);
                occ_d   = occ_q + 1'b1;
              end
            end
            K_PUSH_FRONT: begin
              if (full) begin
                res_status = S_FULL;
              end else begin
                cell_op = C_PUSH_FRONT;
                occ_d   = occ_q + 1'b1;
              end
            end
            K_POP_FRONT: begin
              if (empty) begin
                res_status = S_EMPTY;
              end else begin
                cell_op = C_REMOVE;
                idx_d   = '0;
                occ_d   = occ_q - 1'b1;
              end
            end
            K_POP_BACK: begin
              if (empty) begin
                res_status = S_EMPTY;
              end else begin
                res_pos = POS_W'(occ_q - 1'b1);
                occ_d   = occ_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (match_w[0]) begin
          if (out_free) begin
            res_valid = 1'b1;
            res_pos   = POS_W'(idx_q);
            state_d   = ST_IDLE;
            if (kind_q == K_DELETE) begin
              cell_op = C_REMOVE;
              occ_d   = occ_q - 1'b1;
            end
          end
        end else if (OW'(idx_q) == occ_q - 1'b1) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res_status = S_NOT_FOUND;
            state_d    = ST_IDLE;
          end
        end else begin
          cell_op = C_SCAN;
          idx_d   = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      idx_q   <= idx_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      val_q  <= VALUE_WIDTH'(value_ext);
    end
    if (res_valid) begin
      status_q <= res_status;
      pos_q    <= res_pos;
      count_q  <= COUNT_W'(occ_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign entry_count_o = count_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(CAPACITY))
    else $error("Occupancy exceeds capacity.");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o)
    else $error("Input not stalled while a request is in progress.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q != ST_IDLE))
    else $error("Result word appeared without a request in progress.");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> occ_q != '0)
    else $error("Scan running on an empty list.");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> OW'(idx_q) < occ_q)
    else $error("Scan index beyond the occupied entries.");

endmodule

@@ hdl/bole_cell.sv @@
// One list cell: holds an entry and a match flag, and trades them with its neighbors.
module bole_cell import bole_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_op_e                      op_i,
  input  logic [$clog2(CAPACITY+1)-1:0] occ_i,
  input  logic [$clog2(CAPACITY)-1:0]   idx_i,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  input  logic [VALUE_WIDTH-1:0]        prev_entry_i,
  input  logic [VALUE_WIDTH-1:0]        next_entry_i,
  input  logic                          next_match_i,
  output logic [VALUE_WIDTH-1:0]        entry_o,
  output logic                          match_o
);

  localparam int unsigned OW = $clog2(CAPACITY+1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                   match_q, match_d;
  logic                   in_use;

  assign in_use = OW'(INDEX) < occ_i;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    unique case (op_i)
      C_HOLD: ;
      C_APPEND: begin
        if (OW'(INDEX) == occ_i) entry_d = value_i;
      end
      C_PUSH_FRONT: entry_d = prev_entry_i;
      C_REMOVE: begin
        if (IW'(INDEX) >= idx_i) entry_d = next_entry_i;
      end
      C_COMPARE: match_d = in_use && (entry_q == value_i);
      C_SCAN:    match_d = next_match_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

@@ tb/bole_checker.sv @@
// Scoreboard for the list engine: tracks the list contents and checks every result word.
module bole_checker import bole_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [KIND_W-1:0]            kind_i,
  input  logic signed [IN_VALUE_W-1:0] value_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [STATUS_W-1:0]          status_i,
  input  logic [POS_W-1:0]             position_i,
  input  logic [COUNT_W-1:0]           entry_count_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o
);

  localparam int unsigned DEPTH = CAPACITY_DEF;

  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     pos;
    logic [COUNT_W-1:0]   count;
  } reply_t;

  logic signed [IN_VALUE_W-1:0] list_vals [DEPTH];
  int unsigned                  list_len = 0;
  reply_t                       replies_due [$];
  int                           err_count = 0;
  int                           due_count = 0;
  int                           word_count = 0;

  assign errors_o  = err_count;
  assign pending_o = due_count;
  assign checked_o = word_count;

  function automatic void remove_entry(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_len; i++) begin
      list_vals[i] = list_vals[i + 1];
    end
    list_len--;
  endfunction

  function automatic reply_t apply_request(input logic [KIND_W-1:0] k,
                                           input logic signed [IN_VALUE_W-1:0] v);
    reply_t r;
    int     hit;
    r.status = S_OK;
    r.pos    = '0;
    case (k) inside
      K_PUSH_BACK, K_PUSH_FRONT: begin
        if (list_len >= DEPTH) begin
          r.status = S_FULL;
        end else if (k == K_PUSH_BACK) begin
          list_vals[list_len] = v;
          r.pos = POS_W'(list_len);
          list_len++;
        end else begin
          for (int unsigned i = list_len; i > 0; i--) begin
            list_vals[i] = list_vals[i - 1];
          end
          list_vals[0] = v;
          list_len++;
        end
      end
      K_FIND, K_DELETE: begin
        if (list_len == 0) begin
          r.status = S_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < int'(list_len); i++) begin
            if (hit < 0 && list_vals[i] == v) hit = i;
          end
          if (hit < 0) begin
            r.status = S_NOT_FOUND;
          end else begin
            r.pos = POS_W'(hit);
            if (k == K_DELETE) remove_entry(hit);
          end
        end
      end
      K_POP_FRONT: begin
        if (list_len == 0) r.status = S_EMPTY;
        else remove_entry(0);
      end
      K_POP_BACK: begin
        if (list_len == 0) begin
          r.status = S_EMPTY;
        end else begin
          r.pos = POS_W'(list_len - 1);
          list_len--;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t due;
    if (!rst_ni) begin
      list_len = 0;
      replies_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result word: status %0d position %0d entry_count %0d",
                 status_i, position_i, entry_count_i);
          err_count++;
        end else begin
          due = replies_due.pop_front();
          word_count++;
          if (status_i !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status_i);
            err_count++;
          end
          if (position_i !== due.pos) begin
            $error("position: expected %0d, got %0d", due.pos, position_i);
            err_count++;
          end
          if (entry_count_i !== due.count) begin
            $error("entry_count: expected %0d, got %0d", due.count, entry_count_i);
            err_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        replies_due.push_back(apply_request(kind_i, value_i));
      end
    end
    due_count = replies_due.size();
  end

endmodule

@@ tb/tb_bounded_ordered_list_engine_unit.sv @@
// Testbench top for the list engine: request stimulus, flow control, watchdog and verdict.
module tb_bounded_ordered_list_engine_unit;
  import bole_pkg::*;

  localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;
  localparam int RANDOM_PER_PHASE = 131;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 24;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [KIND_W-1:0]            kind = K_PUSH_BACK;
  logic signed [IN_VALUE_W-1:0] value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [STATUS_W-1:0]          status;
  logic [POS_W-1:0]             position;
  logic [COUNT_W-1:0]           entry_count;

  int errors;
  int pending;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int directed = 0;
  int quiet_cycles = 0;

  bounded_ordered_list_engine_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .position_o    (position),
    .entry_count_o (entry_count)
  );

  bole_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .kind_i        (kind),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .position_i    (position),
    .entry_count_i (entry_count),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] k, input logic signed [IN_VALUE_W-1:0] v);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [IN_VALUE_W-1:0] pick_value();
    if ($urandom_range(99) >= 85) return $urandom;
    case ($urandom_range(7))
      0: return 32'sd0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h5555_5555;
      6: return 32'hAAAA_AAAA;
      default: return 32'sd7;
    endcase
  endfunction

  initial begin : stimulus
    logic [KIND_W-1:0] k;
    bit                filling;
    int                counted;
    int                r;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-list requests, extremes, misses, unused codes and one-entry removal.
    send_word(K_POP_FRONT, 32'sd0);
    send_word(K_POP_BACK, 32'sd0);
    send_word(K_FIND, 32'sd5);
    send_word(K_DELETE, 32'sd5);
    send_word(K_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(K_PUSH_FRONT, 32'h8000_0000);
    send_word(K_PUSH_BACK, -32'sd1);
    send_word(K_PUSH_BACK, 32'sd0);
    send_word(K_FIND, -32'sd1);
    send_word(K_FIND, 32'h1234_5678);
    send_word(K_DELETE, 32'h5555_5555);
    send_word(K_SPARE_LO, 32'sd3);
    send_word(K_SPARE_HI, 32'sd3);
    send_word(K_DELETE, 32'h8000_0000);
    send_word(K_FIND, 32'sd0);
    send_word(K_POP_BACK, 32'sd0);
    send_word(K_POP_FRONT, 32'sd0);
    send_word(K_POP_BACK, 32'sd0);
    send_word(K_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(K_DELETE, 32'hAAAA_AAAA);
    directed = sent;

    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        if ($urandom_range(11) == 0) filling = !filling;
        r = $urandom_range(99);
        if (r < 3) begin
          k = $urandom_range(1) ? K_SPARE_HI : K_SPARE_LO;
        end else if (filling) begin
          if (r < 40) k = K_PUSH_BACK;
          else if (r < 70) k = K_PUSH_FRONT;
          else if (r < 82) k = K_FIND;
          else if (r < 92) k = K_DELETE;
          else if (r < 96) k = K_POP_FRONT;
          else k = K_POP_BACK;
        end else begin
          if (r < 10) k = K_PUSH_BACK;
          else if (r < 15) k = K_PUSH_FRONT;
          else if (r < 28) k = K_FIND;
          else if (r < 45) k = K_DELETE;
          else if (r < 72) k = K_POP_FRONT;
          else k = K_POP_BACK;
        end
        send_word(k, pick_value());
        if (k != K_SPARE_LO && k != K_SPARE_HI) counted++;
      end
    end

    in_valid  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed, the rest random in four flow-control phases).",
             sent, directed);
    $display("Checked %0d result words against the predicted list state.", checked);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
